### hdl/sat_pkg.sv
// Shared types for the section address translator.
// Holds the action and status codes and the transaction token that moves along the cell chain.
// No dependencies.
package sat_pkg;

    localparam int MAX_SECTIONS_DEFAULT = 16;

    typedef enum logic [1:0] {
        ACT_CLEAR     = 2'd0,
        ACT_ADD       = 2'd1,
        ACT_RELOCATE  = 2'd2,
        ACT_TRANSLATE = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        act_t        action;
        logic [31:0] key;
        logic [31:0] size;
        logic [31:0] data;
        logic        wrap;
        logic        full;
        logic        hit;
        logic [31:0] result;
    } token_t;

endpackage

### hdl/sat_cell.sv
// One cell of the translation chain: holds one section entry.
// Acts on the transaction token passing through and hands it to the next cell.
// Depends on sat_pkg.
module sat_cell
    import sat_pkg::*;
#(
    parameter int MAX_SECTIONS = MAX_SECTIONS_DEFAULT,
    parameter int CELL_INDEX   = 0,
    localparam int CW          = $clog2(MAX_SECTIONS + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          valid_i,
    input  token_t        tok_i,
    input  logic [CW-1:0] cnt_i,
    output logic          valid_o,
    output token_t        tok_o,
    output logic [CW-1:0] cnt_o
);

    logic [31:0]   vbase_reg;
    logic [31:0]   size_reg;
    logic [31:0]   rbase_reg;
    logic          wrap_reg;
    logic          valid_reg;
    token_t        tok_reg;
    logic [CW-1:0] cnt_reg;

    logic          in_use;
    logic          is_slot;
    logic [32:0]   diff;
    logic          match;
    token_t        tok_next;

    assign in_use  = cnt_i > CW'(CELL_INDEX);
    assign is_slot = cnt_i == CW'(CELL_INDEX);
    assign diff    = {1'b0, tok_i.key} - {1'b0, vbase_reg};
    assign match   = in_use && !wrap_reg && !diff[32] && (diff[31:0] < size_reg);

    always_comb begin
        tok_next = tok_i;
        if (tok_i.action == ACT_TRANSLATE && !tok_i.hit && match) begin
            tok_next.hit    = 1'b1;
            tok_next.result = rbase_reg + diff[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tok_reg <= tok_next;
            cnt_reg <= cnt_i;
            if (valid_i && tok_i.action == ACT_ADD && !tok_i.full && is_slot) begin
                vbase_reg <= tok_i.key;
                size_reg  <= tok_i.size;
                rbase_reg <= tok_i.data;
                wrap_reg  <= tok_i.wrap;
            end else if (valid_i && tok_i.action == ACT_RELOCATE && in_use) begin
                rbase_reg <= rbase_reg + tok_i.data;
            end
        end
    end

    assign valid_o = valid_reg;
    assign tok_o   = tok_reg;
    assign cnt_o   = cnt_reg;

endmodule

### hdl/section_address_translator_top.sv
// Top level of the section address translator: entry count, token launch, cell chain.
// Depends on sat_pkg and sat_cell.
//
//   channel | direction | ports
//   s_      | in        | s_valid s_ready s_action s_virtual_base s_section_size
//           |           | s_real_base s_relocation_offset s_lookup_address
//   m_      | out       | m_valid m_ready m_translated_address m_status
//
// While the chain advances, a transaction moves one cell per cycle, one cell per section, and
// one new one is taken per cycle; each follows the previous one down the chain, so it sees
// every earlier update. A low m_ready with a result waiting freezes the whole chain and holds
// the result. Reset clears the section count and all stage valid bits; entries are not cleared.
module section_address_translator_top
    import sat_pkg::*;
#(
    parameter int MAX_SECTIONS = MAX_SECTIONS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_virtual_base,
    input  logic [31:0] s_section_size,
    input  logic [31:0] s_real_base,
    input  logic [31:0] s_relocation_offset,
    input  logic [31:0] s_lookup_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_translated_address,
    output logic [1:0]  m_status
);

    localparam int CW = $clog2(MAX_SECTIONS + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          adv;
    logic          accept;
    logic          full;
    logic [32:0]   end_sum;
    act_t          act;
    status_t       status;
    token_t        tok_launch;

    logic          valid_chain [MAX_SECTIONS+1];
    token_t        tok_chain   [MAX_SECTIONS+1];
    logic [CW-1:0] cnt_chain   [MAX_SECTIONS+1];

    assign adv     = !valid_chain[MAX_SECTIONS] || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && adv;
    assign act     = act_t'(s_action);
    assign full    = count_reg == CW'(MAX_SECTIONS);
    assign end_sum = {1'b0, s_virtual_base} + {1'b0, s_section_size};

    always_comb begin
        count_next = count_reg;
        if (accept) begin
            case (act)
                ACT_CLEAR: count_next = '0;
                ACT_ADD:   if (!full) count_next = count_reg + CW'(1);
                default:   count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_comb begin
        tok_launch.action = act;
        tok_launch.key    = (act == ACT_ADD) ? s_virtual_base : s_lookup_address;
        tok_launch.size   = s_section_size;
        tok_launch.data   = (act == ACT_ADD) ? s_real_base : s_relocation_offset;
        tok_launch.wrap   = end_sum[32];
        tok_launch.full   = full;
        tok_launch.hit    = 1'b0;
        tok_launch.result = '0;
    end

    assign tok_chain[0]   = tok_launch;
    assign valid_chain[0] = s_valid;
    assign cnt_chain[0]   = count_reg;

    for (genvar g = 0; g < MAX_SECTIONS; g++) begin : g_cell
        sat_cell #(
            .MAX_SECTIONS (MAX_SECTIONS),
            .CELL_INDEX   (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .valid_i (valid_chain[g]),
            .tok_i   (tok_chain[g]),
            .cnt_i   (cnt_chain[g]),
            .valid_o (valid_chain[g+1]),
            .tok_o   (tok_chain[g+1]),
            .cnt_o   (cnt_chain[g+1])
        );
    end

    always_comb begin
        case (tok_chain[MAX_SECTIONS].action)
            ACT_ADD:       status = tok_chain[MAX_SECTIONS].full ? ST_FULL : ST_OK;
            ACT_TRANSLATE: status = tok_chain[MAX_SECTIONS].hit ? ST_OK : ST_MISS;
            default:       status = ST_OK;
        endcase
    end

    assign m_valid              = valid_chain[MAX_SECTIONS];
    assign m_translated_address = tok_chain[MAX_SECTIONS].result;
    assign m_status             = status;

endmodule
